// ----- hdl/mhm_pkg.sv -----
package mhm_pkg;

    localparam int CHAR_W  = 21;
    localparam int LINE_W  = 16;
    localparam int COL_W   = 12;
    localparam int COLOR_W = 32;
    localparam int NEST_W  = 8;
    localparam int LEVEL_W = 3;

    localparam logic [NEST_W-1:0]  MAX_NEST  = NEST_W'(255);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(7);

    localparam logic [COLOR_W-1:0] FG_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COL_H1   = 32'h4194_D4FF;
    localparam logic [COLOR_W-1:0] COL_H2   = 32'hC266_3AFF;
    localparam logic [COLOR_W-1:0] COL_H3   = 32'h00DB_DBA9;
    localparam logic [COLOR_W-1:0] COL_H4   = 32'h4EC3_7FFF;
    localparam logic [COLOR_W-1:0] COL_H6   = 32'hC185_BCFF;

    localparam logic [CHAR_W-1:0] CH_NL     = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_HASH   = CHAR_W'(35);
    localparam logic [CHAR_W-1:0] CH_STAR   = CHAR_W'(42);
    localparam logic [CHAR_W-1:0] CH_PLUS   = CHAR_W'(43);
    localparam logic [CHAR_W-1:0] CH_MINUS  = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CH_LANGLE = CHAR_W'(60);
    localparam logic [CHAR_W-1:0] CH_RANGLE = CHAR_W'(62);
    localparam logic [CHAR_W-1:0] CH_LSQ    = CHAR_W'(91);
    localparam logic [CHAR_W-1:0] CH_RSQ    = CHAR_W'(93);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_HASH   = 3'd1,
        M_BODY   = 3'd2,
        M_SPACE  = 3'd3,
        M_SQUARE = 3'd4,
        M_ANGLE  = 3'd5,
        M_SKIP   = 3'd6
    } t_mode;

    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   column;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_mark;

    function automatic logic [COLOR_W-1:0] level_color(
        input logic [LEVEL_W-1:0] lvl,
        input logic [COLOR_W-1:0] fg
    );
        logic [COLOR_W-1:0] col;
        case (lvl)
            3'd1:    col = COL_H1;
            3'd2:    col = COL_H2;
            3'd3:    col = COL_H3;
            3'd4:    col = COL_H4;
            3'd5:    col = COL_H1;
            3'd6:    col = COL_H6;
            default: col = fg;
        endcase
        return col;
    endfunction

endpackage

// ----- hdl/mhm_in_if.sv -----
interface mhm_in_if;
    logic                        valid;
    logic                        ready;
    logic [mhm_pkg::CHAR_W-1:0]  char_code;
    logic [mhm_pkg::LINE_W-1:0]  line_number;
    logic [mhm_pkg::COL_W-1:0]   column_number;
    logic                        last_char;

    modport source (output valid, char_code, line_number, column_number, last_char,
                    input ready);
    modport sink   (input valid, char_code, line_number, column_number, last_char,
                    output ready);
endinterface

// ----- hdl/mhm_out_if.sv -----
interface mhm_out_if;
    logic                        valid;
    logic                        ready;
    logic [mhm_pkg::LINE_W-1:0]  mark_line;
    logic [mhm_pkg::COL_W-1:0]   mark_column;
    logic [mhm_pkg::COLOR_W-1:0] mark_color;
    logic                        last_mark;

    modport source (output valid, mark_line, mark_column, mark_color, last_mark,
                    input ready);
    modport sink   (input valid, mark_line, mark_column, mark_color, last_mark,
                    output ready);
endinterface

// ----- hdl/markdown_highlight_marker.sv -----
// Colour marker for a markdown-like highlighter.
// i_in takes one character beat (code point, line, column, last flag); o_mark
// gives colour mark beats (line, column, colour word, last-mark flag). One
// character gives zero, one or two marks; last_mark flags the final one.
// i_cfg_we/i_cfg_wdata write the foreground colour; write only while idle.
// The scan state is updated in the cycle the character is accepted and its
// marks are registered into a four-entry output queue, from which o_mark
// offers them in order.
// i_in.ready is high while the queue has room for two marks: one character
// per cycle is taken as long as the sink drains one mark per cycle, and a
// character that gives two marks fills the queue faster than it drains.
// When o_mark is stalled, marks wait in the queue and i_in.ready drops once
// fewer than two entries are free; nothing is lost or repeated.
// Synchronous reset (i_rst_n low) empties the queue, returns the scanner to
// normal mode and sets the foreground colour to all ones.
module markdown_highlight_marker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mhm_pkg::COLOR_W-1:0] i_cfg_wdata,
    mhm_in_if.sink                      i_in,
    mhm_out_if.source                   o_mark
);
    import mhm_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    logic [COLOR_W-1:0] r_fg;
    t_mode              r_mode,  n_mode;
    logic [LINE_W-1:0]  r_sline, n_sline;
    logic [COL_W-1:0]   r_scol,  n_scol;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_still, n_still;
    logic [NEST_W-1:0]  r_depth, n_depth;

    t_mark              r_queue [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    t_mark              m0, m1;
    logic [1:0]         mcnt;
    logic               accept, pop;

    logic [CHAR_W-1:0]  c;
    logic               c_special;
    t_mode              pl_mode;
    logic [CHAR_W-1:0]  sp_open, sp_close;
    logic [COLOR_W-1:0] sp_color;
    logic [LEVEL_W-1:0] lvl_up;
    logic [NEST_W-1:0]  dec_depth;

    assign c      = i_in.char_code;
    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_mark.valid && o_mark.ready;

    assign i_in.ready = r_count <= (QPTR_W+1)'(QDEPTH - 2);

    // what a plain character would start
    always_comb begin
        c_special = 1'b1;
        pl_mode   = M_NORMAL;
        if (c == CH_HASH) begin
            pl_mode = M_HASH;
        end else if (c == CH_SPACE) begin
            pl_mode = M_SPACE;
        end else if (c == CH_LSQ) begin
            pl_mode = M_SQUARE;
        end else if (c == CH_LANGLE) begin
            pl_mode = M_ANGLE;
        end else begin
            c_special = 1'b0;
        end
    end

    always_comb begin
        if (r_mode == M_ANGLE) begin
            sp_open  = CH_LANGLE;
            sp_close = CH_RANGLE;
            sp_color = COL_H6;
        end else begin
            sp_open  = CH_LSQ;
            sp_close = CH_RSQ;
            sp_color = COL_H4;
        end
    end

    assign lvl_up    = (r_level < LEVEL_MAX) ? r_level + LEVEL_W'(1) : r_level;
    assign dec_depth = (r_depth != '0) ? r_depth - NEST_W'(1) : r_depth;

    always_comb begin
        n_mode  = r_mode;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_level = r_level;
        n_still = r_still;
        n_depth = r_depth;
        m0      = '0;
        m1      = '0;
        mcnt    = 2'd0;
        case (r_mode)
            M_HASH: begin
                if (c == CH_SPACE || c == CH_HASH) begin
                    m0      = '{r_sline, r_scol, COL_H1, 1'b0};
                    n_mode  = M_BODY;
                    if (c == CH_HASH) begin
                        n_level = LEVEL_W'(2);
                        n_still = 1'b1;
                        m1      = '{r_sline, r_scol, COL_H2, 1'b0};
                        mcnt    = 2'd2;
                    end else begin
                        n_level = LEVEL_W'(1);
                        n_still = 1'b0;
                        mcnt    = 2'd1;
                    end
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            M_BODY: begin
                if (c == CH_NL) begin
                    n_mode = M_NORMAL;
                    m0     = '{i_in.line_number, i_in.column_number, r_fg, 1'b0};
                    mcnt   = 2'd1;
                end else if (c == CH_HASH && r_still) begin
                    n_level = lvl_up;
                    m0      = '{r_sline, r_scol, level_color(lvl_up, r_fg), 1'b0};
                    mcnt    = 2'd1;
                end else begin
                    n_still = 1'b0;
                end
            end
            M_SPACE: begin
                if (c == CH_MINUS || c == CH_STAR || c == CH_PLUS) begin
                    m0     = '{r_sline, r_scol, COL_H2, 1'b0};
                    n_mode = M_NORMAL;
                    mcnt   = 2'd1;
                end else begin
                    m0     = '{r_sline, r_scol, r_fg, 1'b0};
                    n_mode = pl_mode;
                    if (c_special) begin
                        n_sline = i_in.line_number;
                        n_scol  = i_in.column_number;
                        if (pl_mode == M_SQUARE || pl_mode == M_ANGLE) begin
                            n_depth = NEST_W'(1);
                        end
                        mcnt = 2'd1;
                    end else begin
                        m1   = '{i_in.line_number, i_in.column_number, r_fg, 1'b0};
                        mcnt = 2'd2;
                    end
                end
            end
            M_SQUARE, M_ANGLE: begin
                if (c == sp_open) begin
                    if (r_depth < MAX_NEST) begin
                        n_depth = r_depth + NEST_W'(1);
                    end
                end else if (c == sp_close) begin
                    n_depth = dec_depth;
                    if (dec_depth == '0) begin
                        n_mode = M_SKIP;
                        m0     = '{r_sline, r_scol, sp_color, 1'b0};
                        mcnt   = 2'd1;
                    end
                end else if (c == CH_NL) begin
                    n_depth = '0;
                    n_mode  = M_NORMAL;
                    m0      = '{i_in.line_number, i_in.column_number, r_fg, 1'b0};
                    mcnt    = 2'd1;
                end
            end
            M_SKIP: begin
                m0     = '{i_in.line_number, i_in.column_number, r_fg, 1'b0};
                n_mode = M_NORMAL;
                mcnt   = 2'd1;
            end
            default: begin
                n_mode = pl_mode;
                if (c_special) begin
                    n_sline = i_in.line_number;
                    n_scol  = i_in.column_number;
                    if (pl_mode == M_SQUARE || pl_mode == M_ANGLE) begin
                        n_depth = NEST_W'(1);
                    end
                end else begin
                    m0   = '{i_in.line_number, i_in.column_number, r_fg, 1'b0};
                    mcnt = 2'd1;
                end
            end
        endcase
        m0.last = (mcnt == 2'd1);
        m1.last = 1'b1;
        if (i_in.last_char) begin
            n_mode  = M_NORMAL;
            n_sline = '0;
            n_scol  = '0;
            n_level = '0;
            n_still = 1'b0;
            n_depth = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= FG_RESET;
            r_mode  <= M_NORMAL;
            r_sline <= '0;
            r_scol  <= '0;
            r_level <= '0;
            r_still <= 1'b0;
            r_depth <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fg <= i_cfg_wdata;
            end
            if (accept) begin
                r_mode  <= n_mode;
                r_sline <= n_sline;
                r_scol  <= n_scol;
                r_level <= n_level;
                r_still <= n_still;
                r_depth <= n_depth;
            end
        end
    end

    // mark queue: up to two pushes and one pop per cycle
    always_ff @(posedge i_clk) begin
        if (accept && mcnt != 2'd0) begin
            r_queue[r_wr_ptr] <= m0;
        end
        if (accept && mcnt == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(mcnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (accept ? (QPTR_W+1)'(mcnt) : '0)
                               - (pop ? (QPTR_W+1)'(1) : '0);
        end
    end

    assign o_mark.valid       = r_count != '0;
    assign o_mark.mark_line   = r_queue[r_rd_ptr].line;
    assign o_mark.mark_column = r_queue[r_rd_ptr].column;
    assign o_mark.mark_color  = r_queue[r_rd_ptr].color;
    assign o_mark.last_mark   = r_queue[r_rd_ptr].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("mark queue overfilled");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last_char) |=> (r_mode == M_NORMAL && r_depth == '0))
        else $error("scan state not cleared after final character");

    a_depth_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_mode == M_SQUARE || r_mode == M_ANGLE))
        else $error("bracket depth held outside a span");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && pop) |=> (r_count == $past(r_count) - (QPTR_W+1)'(1)))
        else $error("queue count lost a pop");

endmodule
